### hw/rtl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasteriser.
`default_nettype none
package mlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int POS_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;
  typedef logic        [POS_BITS-1:0]   delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  // sorted endpoints after the first front stage
  typedef struct packed {
    op_e    op;
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
    logic   mirrored;
  } sorted_t;

  // classified request handed from front to back
  typedef struct packed {
    op_e    op;
    pos_t   major_pos;
    pos_t   minor_pos;
    pos_t   major_end;
    delta_t delta_major;
    delta_t delta_minor;
    logic   swapped;
    logic   mirrored;
  } cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   valid;
    logic   last;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/mlr_front.sv
// Front end: accepts requests, sorts endpoints, mirrors y and picks the major axis.
`default_nettype none
module mlr_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire mlr_pkg::op_e        op_i,
  input  wire mlr_pkg::coord_t     x_start_i,
  input  wire mlr_pkg::coord_t     y_start_i,
  input  wire mlr_pkg::coord_t     x_end_i,
  input  wire mlr_pkg::coord_t     y_end_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output mlr_pkg::cmd_t            cmd_o
);

  function automatic mlr_pkg::pos_t ext_pos(mlr_pkg::coord_t c);
    return {c[mlr_pkg::COORD_BITS-1], c};
  endfunction

  logic             s1_v_q, s1_v_d;
  logic             s2_v_q, s2_v_d;
  logic             s1_ready, s2_ready;
  logic             s1_load, s2_load;
  mlr_pkg::sorted_t s1_q, s1_d;
  mlr_pkg::cmd_t    s2_q, s2_d;
  logic             swap_ends;

  mlr_pkg::pos_t    xa_p, ya_p, xb_p, yb_p;
  mlr_pkg::pos_t    ya_m, yb_m, dx, dy;
  logic             swapped;

  assign s2_ready = !s2_v_q || !q_full_i;
  assign s1_ready = !s1_v_q || s2_ready;
  assign full     = !s1_ready;
  assign s1_load  = push && s1_ready;
  assign s2_load  = s2_ready && s1_v_q;
  assign q_push_o = s2_v_q && !q_full_i;
  assign cmd_o    = s2_q;

  // stage 1: left-to-right order, mirror flag from the ordered pair
  always_comb begin
    swap_ends      = x_start_i > x_end_i;
    s1_d.op        = op_i;
    s1_d.xa        = swap_ends ? x_end_i   : x_start_i;
    s1_d.ya        = swap_ends ? y_end_i   : y_start_i;
    s1_d.xb        = swap_ends ? x_start_i : x_end_i;
    s1_d.yb        = swap_ends ? y_start_i : y_end_i;
    s1_d.mirrored  = swap_ends ? (y_start_i < y_end_i) : (y_end_i < y_start_i);
  end

  // stage 2: deltas and axis choice
  always_comb begin
    xa_p    = ext_pos(s1_q.xa);
    ya_p    = ext_pos(s1_q.ya);
    xb_p    = ext_pos(s1_q.xb);
    yb_p    = ext_pos(s1_q.yb);
    ya_m    = s1_q.mirrored ? -ya_p : ya_p;
    yb_m    = s1_q.mirrored ? -yb_p : yb_p;
    dx      = xb_p - xa_p;
    dy      = s1_q.mirrored ? (ya_p - yb_p) : (yb_p - ya_p);
    swapped = mlr_pkg::delta_t'(dy) > mlr_pkg::delta_t'(dx);

    s2_d.op          = s1_q.op;
    s2_d.swapped     = swapped;
    s2_d.mirrored    = s1_q.mirrored;
    s2_d.major_pos   = swapped ? ya_m : xa_p;
    s2_d.minor_pos   = swapped ? xa_p : ya_m;
    s2_d.major_end   = swapped ? yb_m : xb_p;
    s2_d.delta_major = swapped ? mlr_pkg::delta_t'(dy) : mlr_pkg::delta_t'(dx);
    s2_d.delta_minor = swapped ? mlr_pkg::delta_t'(dx) : mlr_pkg::delta_t'(dy);
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (s1_load) begin
      s1_v_d = 1'b1;
    end else if (s2_ready) begin
      s1_v_d = 1'b0;
    end
    s2_v_d = s2_ready ? s1_v_q : s2_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s1_d;
    end
    if (s2_load) begin
      s2_q <= s2_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mlr_queue.sv
// Two-entry request queue between front and back ends.
`default_nettype none
module mlr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mlr_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output mlr_pkg::cmd_t      data_o
);

  mlr_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mlr_back.sv
// Back end: walks the line one major step per request and queues the pixels.
`default_nettype none
module mlr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_empty_i,
  input  wire mlr_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output mlr_pkg::result_t   res_o
);

  function automatic mlr_pkg::err_t ext_err(mlr_pkg::delta_t d);
    return {{(mlr_pkg::ERR_BITS-mlr_pkg::POS_BITS){1'b0}}, d};
  endfunction

  function automatic mlr_pkg::result_t map_pixel(mlr_pkg::pos_t maj, mlr_pkg::pos_t mnr,
                                                 logic sw, logic mir, logic last);
    mlr_pkg::result_t r;
    mlr_pkg::pos_t    px, py;
    px      = sw ? mnr : maj;
    py      = sw ? maj : mnr;
    py      = mir ? -py : py;
    r.x     = px[mlr_pkg::COORD_BITS-1:0];
    r.y     = py[mlr_pkg::COORD_BITS-1:0];
    r.valid = 1'b1;
    r.last  = last;
    return r;
  endfunction

  mlr_pkg::pos_t major_pos_q, major_pos_d;
  mlr_pkg::pos_t minor_pos_q, minor_pos_d;
  mlr_pkg::pos_t major_end_q, major_end_d;
  mlr_pkg::err_t err_q, err_d;
  mlr_pkg::err_t inc_diag_q, inc_diag_d;
  mlr_pkg::err_t inc_flat_q, inc_flat_d;
  logic          swapped_q, swapped_d;
  logic          mirrored_q, mirrored_d;
  logic          active_q, active_d;

  mlr_pkg::result_t res_d;
  mlr_pkg::pos_t    maj_n, min_n;
  logic             step_minor, last;

  // result queue
  mlr_pkg::result_t rq_q [2];
  logic             rq_wr_q, rq_rd_q;
  logic [1:0]       rq_cnt_q, rq_cnt_d;
  logic             rq_full, rq_pop;

  assign rq_full   = rq_cnt_q == 2'd2;
  assign cmd_pop_o = !cmd_empty_i && !rq_full;
  assign empty     = rq_cnt_q == 2'd0;
  assign rq_pop    = pop && !empty;
  assign res_o     = rq_q[rq_rd_q];

  always_comb begin
    major_pos_d = major_pos_q;
    minor_pos_d = minor_pos_q;
    major_end_d = major_end_q;
    err_d       = err_q;
    inc_diag_d  = inc_diag_q;
    inc_flat_d  = inc_flat_q;
    swapped_d   = swapped_q;
    mirrored_d  = mirrored_q;
    active_d    = active_q;
    res_d       = '0;
    // positive decision only: a tie takes no minor step
    step_minor  = !err_q[mlr_pkg::ERR_BITS-1] && (err_q != '0);
    maj_n       = major_pos_q + mlr_pkg::pos_t'(1);
    min_n       = step_minor ? (minor_pos_q + mlr_pkg::pos_t'(1)) : minor_pos_q;
    last        = 1'b0;
    if (cmd_pop_o) begin
      case (cmd_i.op)
        mlr_pkg::OP_START: begin
          major_pos_d = cmd_i.major_pos;
          minor_pos_d = cmd_i.minor_pos;
          major_end_d = cmd_i.major_end;
          err_d       = (ext_err(cmd_i.delta_minor) <<< 1) - ext_err(cmd_i.delta_major);
          inc_flat_d  = ext_err(cmd_i.delta_minor) <<< 1;
          inc_diag_d  = (ext_err(cmd_i.delta_minor) - ext_err(cmd_i.delta_major)) <<< 1;
          swapped_d   = cmd_i.swapped;
          mirrored_d  = cmd_i.mirrored;
          last        = cmd_i.major_pos == cmd_i.major_end;
          active_d    = !last;
          res_d       = map_pixel(cmd_i.major_pos, cmd_i.minor_pos, cmd_i.swapped,
                                  cmd_i.mirrored, last);
        end
        mlr_pkg::OP_NEXT: begin
          if (active_q) begin
            major_pos_d = maj_n;
            minor_pos_d = min_n;
            err_d       = err_q + (step_minor ? inc_diag_q : inc_flat_q);
            last        = maj_n >= major_end_q;
            active_d    = !last;
            res_d       = map_pixel(maj_n, min_n, swapped_q, mirrored_q, last);
          end
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    if (cmd_pop_o && !rq_pop) begin
      rq_cnt_d = rq_cnt_q + 2'd1;
    end else if (rq_pop && !cmd_pop_o) begin
      rq_cnt_d = rq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_pos_q <= '0;
      minor_pos_q <= '0;
      major_end_q <= '0;
      err_q       <= '0;
      inc_diag_q  <= '0;
      inc_flat_q  <= '0;
      swapped_q   <= 1'b0;
      mirrored_q  <= 1'b0;
      active_q    <= 1'b0;
      rq_wr_q     <= 1'b0;
      rq_rd_q     <= 1'b0;
      rq_cnt_q    <= 2'd0;
    end else begin
      major_pos_q <= major_pos_d;
      minor_pos_q <= minor_pos_d;
      major_end_q <= major_end_d;
      err_q       <= err_d;
      inc_diag_q  <= inc_diag_d;
      inc_flat_q  <= inc_flat_d;
      swapped_q   <= swapped_d;
      mirrored_q  <= mirrored_d;
      active_q    <= active_d;
      rq_wr_q     <= cmd_pop_o ? !rq_wr_q : rq_wr_q;
      rq_rd_q     <= rq_pop ? !rq_rd_q : rq_rd_q;
      rq_cnt_q    <= rq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      rq_q[rq_wr_q] <= res_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/midpoint_line_rasterizer_unit.sv
// Midpoint line rasteriser, all octants: top level.
//
// Requests enter through a queue-style port: push with full; a request is
// taken at a clock edge with push high and full low. op_i low starts a line
// from the four endpoint coordinates and returns its first pixel; op_i high
// returns the next pixel of the current line (pixel_valid_o low if none).
// Exactly one result per request, in request order.
// Results leave through a queue-style port: while empty is low the oldest
// result is on the pixel ports, and it is taken at an edge with pop high.
// A taken request passes the first and second front stages and the middle
// queue, and one back-end step then writes its result to the result queue.
// Throughput: one request per cycle while the result queue has room, set by
// the add-and-compare step in the back end.
// A two-entry queue sits between front and back, and a two-entry queue
// holds results; when pop stays low the queues fill and full rises, with
// nothing lost. Reset clears all queues and leaves no line active.
`default_nettype none
module midpoint_line_rasterizer_unit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    op_i,
  input  wire mlr_pkg::coord_t         x_start_i,
  input  wire mlr_pkg::coord_t         y_start_i,
  input  wire mlr_pkg::coord_t         x_end_i,
  input  wire mlr_pkg::coord_t         y_end_i,
  output logic                         empty,
  input  wire logic                    pop,
  output mlr_pkg::coord_t              pixel_x_o,
  output mlr_pkg::coord_t              pixel_y_o,
  output logic                         pixel_valid_o,
  output logic                         last_pixel_o
);

  logic             q_full, q_push, q_empty, q_pop;
  mlr_pkg::cmd_t    front_cmd, back_cmd;
  mlr_pkg::result_t res;

  mlr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .op_i      (mlr_pkg::op_e'(op_i)),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .cmd_o     (front_cmd)
  );

  mlr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (back_cmd)
  );

  mlr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign pixel_x_o     = res.x;
  assign pixel_y_o     = res.y;
  assign pixel_valid_o = res.valid;
  assign last_pixel_o  = res.last;

endmodule
`default_nettype wire
